[hdl/assert_macros.svh]
// assertion macros shared by the polynomial multiply rtl
// each macro expects clk and rst_n in the scope of its use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is held
`define PM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is held
`define PM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/pm_pkg.sv]
// constants, command codes and shared structs of the polynomial multiplier
// no dependencies
`default_nettype none

package pm_pkg;

  // operand capacity and derived widths
  localparam int MAX_TERMS = 16;
  localparam int IDX_W     = $clog2(MAX_TERMS);
  localparam int CNT_W     = $clog2(MAX_TERMS + 1);
  localparam int POW_W     = 5;
  localparam int COEF_W    = 16;
  localparam int PROD_W    = 2 * COEF_W;
  localparam int TERM_W    = 32;
  localparam int SUM_W     = 37;

  // command codes
  localparam logic [1:0] CMD_LOAD_P = 2'd0;
  localparam logic [1:0] CMD_LOAD_Q = 2'd1;
  localparam logic [1:0] CMD_MULT   = 2'd2;

  // control tag that travels with each coefficient pair read
  typedef struct packed {
    logic             valid;
    logic             first;   // first pair of a term: restart the sum
    logic             last;    // last pair of a term: emit the sum
    logic             fin;     // term is the highest power
    logic             ovf;     // loads were dropped before this multiply
    logic             zero;    // an operand was empty
    logic [POW_W-1:0] power;
  } pm_tag_t;

  // operand memory access request from the sequencer
  typedef struct packed {
    logic              p_we;
    logic              q_we;
    logic [IDX_W-1:0]  waddr;
    logic [COEF_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  p_raddr;
    logic [IDX_W-1:0]  q_raddr;
  } pm_mem_req_t;

  // datapath status back to the sequencer
  typedef struct packed {
    logic pipe_empty;
    logic out_free;
  } pm_mac_stat_t;

endpackage

`default_nettype wire

[hdl/pm_in_if.sv]
// input channel: command and coefficient word with valid/ready
// depends on pm_pkg
`default_nettype none

interface pm_in_if import pm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic signed [COEF_W-1:0] coefficient;

  modport source (output valid, output command, output coefficient, input ready);
  modport sink   (input valid, input command, input coefficient, output ready);
endinterface

`default_nettype wire

[hdl/pm_out_if.sv]
// result channel: one product term word with valid/ready
// depends on pm_pkg
`default_nettype none

interface pm_out_if import pm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [POW_W-1:0]         power;
  logic signed [TERM_W-1:0] product_term;
  logic                     last_term;
  logic                     overflow;

  modport source (output valid, output power, output product_term, output last_term,
                  output overflow, input ready);
  modport sink   (input valid, input power, input product_term, input last_term,
                  input overflow, output ready);
endinterface

`default_nettype wire

[hdl/pm_ram.sv]
// generic single-write, single-read synchronous ram, registered read data
// no dependencies
`default_nettype none

module pm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[hdl/pm_seq.sv]
// sequencer: load handling, operand counts and the convolution address walk
// depends on pm_pkg, pm_in_if, assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module pm_seq import pm_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  pm_in_if.sink       in_chan,
  input  wire pm_mac_stat_t mac_stat,
  output pm_mem_req_t  mem_req,
  output pm_tag_t      tag
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_START = 4'b0010,
    S_ISSUE = 4'b0100,
    S_WAIT  = 4'b1000
  } seq_state_t;

  seq_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] p_cnt_r, p_cnt_nxt;
  logic [CNT_W-1:0] q_cnt_r, q_cnt_nxt;
  logic             drop_r, drop_nxt;
  logic [CNT_W-1:0] lp_r, lp_nxt;
  logic [CNT_W-1:0] lq_r, lq_nxt;
  logic [POW_W-1:0] kmax_r, kmax_nxt;
  logic [POW_W-1:0] k_r, k_nxt;
  logic [POW_W-1:0] i_r, i_nxt;
  logic [POW_W-1:0] ihi_r, ihi_nxt;
  logic             first_r, first_nxt;
  logic             done_r, done_nxt;
  logic             ovf_r, ovf_nxt;
  logic             zero_r, zero_nxt;

  logic             accept;
  logic [POW_W-1:0] lp_w, lq_w;
  logic [POW_W-1:0] j_w;
  logic             last_pair;
  logic [CNT_W:0]   kmax_sum;

  assign in_chan.ready = (state_r == S_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign lp_w          = POW_W'(lp_r);
  assign lq_w          = POW_W'(lq_r);
  assign j_w           = k_r - i_r;
  assign last_pair     = (i_r == ihi_r);

  // operand lengths with an empty operand counted as one zero term
  always_comb begin
    lp_nxt   = (p_cnt_r == '0) ? CNT_W'(1) : p_cnt_r;
    lq_nxt   = (q_cnt_r == '0) ? CNT_W'(1) : q_cnt_r;
    kmax_sum = {1'b0, lp_nxt} + {1'b0, lq_nxt} - (CNT_W + 1)'(2);
  end

  // next state and sequencing
  always_comb begin
    state_nxt = state_r;
    p_cnt_nxt = p_cnt_r;
    q_cnt_nxt = q_cnt_r;
    drop_nxt  = drop_r;
    kmax_nxt  = kmax_r;
    k_nxt     = k_r;
    i_nxt     = i_r;
    ihi_nxt   = ihi_r;
    first_nxt = first_r;
    done_nxt  = done_r;
    ovf_nxt   = ovf_r;
    zero_nxt  = zero_r;

    mem_req         = '0;
    mem_req.waddr   = p_cnt_r[IDX_W-1:0];
    mem_req.wdata   = in_chan.coefficient;
    mem_req.p_raddr = i_r[IDX_W-1:0];
    mem_req.q_raddr = j_w[IDX_W-1:0];

    tag       = '0;
    tag.first = first_r;
    tag.last  = last_pair;
    tag.fin   = (k_r == kmax_r);
    tag.ovf   = ovf_r;
    tag.zero  = zero_r;
    tag.power = k_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_chan.command)
            CMD_LOAD_P: begin
              if (p_cnt_r < CNT_W'(MAX_TERMS)) begin
                mem_req.p_we = 1'b1;
                p_cnt_nxt    = p_cnt_r + CNT_W'(1);
              end else begin
                drop_nxt = 1'b1;
              end
            end
            CMD_LOAD_Q: begin
              mem_req.waddr = q_cnt_r[IDX_W-1:0];
              if (q_cnt_r < CNT_W'(MAX_TERMS)) begin
                mem_req.q_we = 1'b1;
                q_cnt_nxt    = q_cnt_r + CNT_W'(1);
              end else begin
                drop_nxt = 1'b1;
              end
            end
            CMD_MULT: begin
              kmax_nxt  = kmax_sum[POW_W-1:0];
              zero_nxt  = (p_cnt_r == '0) || (q_cnt_r == '0);
              ovf_nxt   = drop_r;
              k_nxt     = '0;
              done_nxt  = 1'b0;
              p_cnt_nxt = '0;
              q_cnt_nxt = '0;
              drop_nxt  = 1'b0;
              state_nxt = S_START;
            end
            default: begin
            end
          endcase
        end
      end
      // index range of the first operand for term k
      S_START: begin
        i_nxt     = (k_r >= lq_w) ? (k_r - lq_w + POW_W'(1)) : '0;
        ihi_nxt   = (k_r < lp_w) ? k_r : (lp_w - POW_W'(1));
        first_nxt = 1'b1;
        state_nxt = S_ISSUE;
      end
      // one coefficient pair read per cycle
      S_ISSUE: begin
        mem_req.re = 1'b1;
        tag.valid  = 1'b1;
        first_nxt  = 1'b0;
        if (last_pair) begin
          done_nxt  = (k_r == kmax_r);
          k_nxt     = k_r + POW_W'(1);
          state_nxt = S_WAIT;
        end else begin
          i_nxt = i_r + POW_W'(1);
        end
      end
      // term drains and its output word is taken before the next one starts
      S_WAIT: begin
        if (mac_stat.pipe_empty && mac_stat.out_free) begin
          state_nxt = done_r ? S_IDLE : S_START;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      p_cnt_r <= '0;
      q_cnt_r <= '0;
      drop_r  <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      p_cnt_r <= p_cnt_nxt;
      q_cnt_r <= q_cnt_nxt;
      drop_r  <= drop_nxt;
      done_r  <= done_nxt;
    end
  end

  // walk registers, loaded before use
  always_ff @(posedge clk) begin
    lp_r    <= (state_r == S_IDLE) ? lp_nxt : lp_r;
    lq_r    <= (state_r == S_IDLE) ? lq_nxt : lq_r;
    kmax_r  <= kmax_nxt;
    k_r     <= k_nxt;
    i_r     <= i_nxt;
    ihi_r   <= ihi_nxt;
    first_r <= first_nxt;
    ovf_r   <= ovf_nxt;
    zero_r  <= zero_nxt;
  end

  `PM_ASSERT_IMP(a_rd_in_range, mem_req.re, (lp_w > i_r) && (lq_w > j_w), "read beyond operand")
  `PM_ASSERT_IMP(a_cnt_cap, 1'b1, (p_cnt_r <= CNT_W'(MAX_TERMS)) && (q_cnt_r <= CNT_W'(MAX_TERMS)), "count over capacity")
  `PM_ASSERT_NXT(a_mult_clears, accept && (in_chan.command == CMD_MULT), (p_cnt_r == '0) && (q_cnt_r == '0) && !drop_r, "multiply did not clear operands")

endmodule

`default_nettype wire

[hdl/pm_mac.sv]
// multiply-accumulate datapath with saturation and the output register
// depends on pm_pkg, pm_out_if, assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module pm_mac import pm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pm_tag_t           tag,
  input  wire logic [COEF_W-1:0] p_rdata,
  input  wire logic [COEF_W-1:0] q_rdata,
  output pm_mac_stat_t           mac_stat,
  pm_out_if.source               out_chan
);

  pm_tag_t                  tag1_r, tag2_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [SUM_W-1:0]  acc_r;
  logic signed [COEF_W-1:0] p_val, q_val;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [SUM_W-1:0]  sum_nxt;
  logic [SUM_W-TERM_W:0]    sum_hi;
  logic [TERM_W-1:0]        sat_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [POW_W-1:0]         power_r;
  logic [TERM_W-1:0]        term_r;
  logic                     last_r;
  logic                     ovf_r;
  logic                     emit;

  // empty operand reads as zero
  assign p_val    = tag1_r.zero ? '0 : $signed(p_rdata);
  assign q_val    = tag1_r.zero ? '0 : $signed(q_rdata);
  assign prod_nxt = p_val * q_val;

  // accumulate and saturate to 32 bits
  always_comb begin
    sum_nxt = (tag2_r.first ? '0 : acc_r) +
              {{(SUM_W - PROD_W){prod_r[PROD_W-1]}}, prod_r};
    sum_hi  = sum_nxt[SUM_W-1:TERM_W-1];
    if ((sum_hi == '0) || (sum_hi == '1)) begin
      sat_nxt = sum_nxt[TERM_W-1:0];
    end else if (sum_nxt[SUM_W-1]) begin
      sat_nxt = {1'b1, {(TERM_W - 1){1'b0}}};
    end else begin
      sat_nxt = {1'b0, {(TERM_W - 1){1'b1}}};
    end
  end

  assign emit = tag2_r.valid && tag2_r.last;

  // output word valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  // pipeline tags and sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r      <= '0;
      tag2_r      <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      tag1_r      <= tag;
      tag2_r      <= tag1_r;
      out_valid_r <= out_valid_nxt;
      if (tag2_r.valid) begin
        acc_r <= sum_nxt;
      end
    end
  end

  // product and output payload
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (emit) begin
      power_r <= tag2_r.power;
      term_r  <= sat_nxt;
      last_r  <= tag2_r.fin;
      ovf_r   <= tag2_r.ovf;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.power        = power_r;
  assign out_chan.product_term = $signed(term_r);
  assign out_chan.last_term    = last_r;
  assign out_chan.overflow     = ovf_r;

  assign mac_stat.pipe_empty = !tag1_r.valid && !tag2_r.valid;
  assign mac_stat.out_free   = !out_valid_r;

  `PM_ASSERT_IMP(a_emit_free, emit, !out_valid_r, "term overwrites pending output word")

endmodule

`default_nettype wire

[hdl/polynomial_multiply_top.sv]
// Polynomial multiplier by discrete convolution, top level.
// Input channel in_chan carries a command and a signed Q8.8 coefficient:
//   load first operand, load second operand, or multiply and emit.
// Up to 16 terms per operand are kept in two operand rams, further loads
//   are dropped and flagged as overflow.
// A multiply emits the product on out_chan, lowest power first, one word per
//   power with signed Q16.16 term, last_term on the highest power and the
//   overflow flag. Both operands and the flag are cleared by the multiply.
// Term k reads n_k coefficient pairs, one pair per cycle from the two ram
//   read ports; a term passes bound setup, the ram reads, multiply and
//   accumulate before its word is ready, and the next term starts
//   once that word has been taken. in_chan is not ready from multiply until
//   the last word has left.
// A stalled receiver holds the current word and pauses the address walk.
// Reset clears counts, the overflow flag and all control; ram contents are
//   not cleared, reads stay within the loaded entries or are masked to zero.
// depends on pm_pkg, pm_in_if, pm_out_if, pm_ram, pm_seq, pm_mac
`default_nettype none

module polynomial_multiply_top import pm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  pm_in_if.sink     in_chan,
  pm_out_if.source  out_chan
);

  pm_mem_req_t       mem_req;
  pm_tag_t           tag;
  pm_mac_stat_t      mac_stat;
  logic [COEF_W-1:0] p_rdata;
  logic [COEF_W-1:0] q_rdata;

  // load handling and address walk
  pm_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .mac_stat (mac_stat),
    .mem_req  (mem_req),
    .tag      (tag)
  );

  // first operand store
  pm_ram #(.WIDTH(COEF_W), .DEPTH(MAX_TERMS)) u_p_ram (
    .clk   (clk),
    .we    (mem_req.p_we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.p_raddr),
    .rdata (p_rdata)
  );

  // second operand store
  pm_ram #(.WIDTH(COEF_W), .DEPTH(MAX_TERMS)) u_q_ram (
    .clk   (clk),
    .we    (mem_req.q_we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.q_raddr),
    .rdata (q_rdata)
  );

  // multiply-accumulate and output word
  pm_mac u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .tag      (tag),
    .p_rdata  (p_rdata),
    .q_rdata  (q_rdata),
    .mac_stat (mac_stat),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire

[dv/testbench.sv]
// self-checking testbench for polynomial_multiply_top: loads, multiplies, unused codes
// depends on pm_pkg, pm_in_if, pm_out_if and the polynomial_multiply_top rtl
`default_nettype none

module testbench;
  import pm_pkg::*;

  // code the block leaves unused, sent as noise
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam longint TERM_MAX = (longint'(1) <<< (TERM_W - 1)) - 1;
  localparam longint TERM_MIN = -(longint'(1) <<< (TERM_W - 1));
  localparam int HOLD_CYCLES = 500;
  localparam int TAIL_CYCLES = 60;
  localparam int RANDOM_WORDS = 340;

  // one product term as it leaves the block
  typedef struct {
    logic [POW_W-1:0]         power;
    logic signed [TERM_W-1:0] product_term;
    logic                     last_term;
    logic                     overflow;
  } term_word_t;

  // operand stores, counts and the product terms still owed by the block
  class convolution_tracker;
    logic signed [COEF_W-1:0] first_store[MAX_TERMS];
    logic signed [COEF_W-1:0] second_store[MAX_TERMS];
    int first_count;
    int second_count;
    bit dropped;
    term_word_t pending_terms[$];
    int error_count;

    function new();
      first_count = 0;
      second_count = 0;
      dropped = 1'b0;
      error_count = 0;
    endfunction

    // update the operands on a load, or queue the product terms on a multiply
    function void accept_word(logic [1:0] command, logic signed [COEF_W-1:0] coef);
      int first_len;
      int second_len;
      int n_terms;
      longint acc;
      term_word_t t;
      case (command)
        CMD_LOAD_P: begin
          if (first_count < MAX_TERMS) begin
            first_store[first_count] = coef;
            first_count++;
          end else begin
            dropped = 1'b1;
          end
        end
        CMD_LOAD_Q: begin
          if (second_count < MAX_TERMS) begin
            second_store[second_count] = coef;
            second_count++;
          end else begin
            dropped = 1'b1;
          end
        end
        CMD_MULT: begin
          // an empty operand acts as the single term zero
          first_len  = (first_count == 0) ? 1 : first_count;
          second_len = (second_count == 0) ? 1 : second_count;
          n_terms = first_len + second_len - 1;
          for (int k = 0; k < n_terms; k++) begin
            acc = 0;
            if (first_count != 0 && second_count != 0) begin
              for (int i = 0; i <= k && i < first_len; i++) begin
                if (k - i < second_len)
                  acc += longint'(first_store[i]) * longint'(second_store[k - i]);
              end
            end
            if (acc > TERM_MAX) acc = TERM_MAX;
            if (acc < TERM_MIN) acc = TERM_MIN;
            t.power = k[POW_W-1:0];
            t.product_term = acc[TERM_W-1:0];
            t.last_term = (k == n_terms - 1);
            t.overflow = dropped;
            pending_terms.push_back(t);
          end
          first_count = 0;
          second_count = 0;
          dropped = 1'b0;
        end
        default: ;
      endcase
    endfunction

    // compare one received term with the oldest owed term
    function void check_word(term_word_t seen);
      term_word_t want;
      if (pending_terms.size() == 0) begin
        $error("unexpected product term: power %0d, product_term %0d",
               seen.power, seen.product_term);
        error_count++;
        return;
      end
      want = pending_terms.pop_front();
      if (seen.power !== want.power) begin
        $error("power: expected %0d, actual %0d", want.power, seen.power);
        error_count++;
      end
      if (seen.product_term !== want.product_term) begin
        $error("product_term: expected %0d, actual %0d", want.product_term,
               seen.product_term);
        error_count++;
      end
      if (seen.last_term !== want.last_term) begin
        $error("last_term: expected %0b, actual %0b", want.last_term, seen.last_term);
        error_count++;
      end
      if (seen.overflow !== want.overflow) begin
        $error("overflow: expected %0b, actual %0b", want.overflow, seen.overflow);
        error_count++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  pm_in_if  in_chan ();
  pm_out_if out_chan ();

  convolution_tracker conv = new();

  // sender state
  int  burst_left = 1;
  bit  gaps_on = 1'b1;
  int  words_sent = 0;
  // long receiver hold-off, requested by the sender side
  bit  hold_request = 1'b0;

  polynomial_multiply_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // offer one word, wait for its handshake, then maybe leave a gap
  task automatic send_word(logic [1:0] command, logic signed [COEF_W-1:0] coef);
    in_chan.valid       <= 1'b1;
    in_chan.command     <= command;
    in_chan.coefficient <= coef;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    conv.accept_word(command, coef);
    if (command != CMD_UNUSED) words_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) begin
        in_chan.valid <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
    end
  endtask

  // stop sending until every owed term has been received
  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (conv.pending_terms.size() != 0);
  endtask

  // operand length, mostly short, sometimes past capacity
  function automatic int pick_len();
    int roll;
    roll = $urandom_range(0, 11);
    if (roll == 0) return $urandom_range(MAX_TERMS + 1, MAX_TERMS + 4);
    if (roll < 4) return $urandom_range(9, MAX_TERMS);
    return $urandom_range(0, 8);
  endfunction

  // coefficient mix: extremes, small values and full range
  function automatic logic signed [COEF_W-1:0] pick_coef(bit heavy);
    int roll;
    roll = $urandom_range(0, 9);
    if (heavy) return (roll < 5) ? -16'sd32768 : 16'sd32767;
    case (roll)
      0:       return -16'sd32768;
      1:       return 16'sd32767;
      2, 3, 4: return COEF_W'($urandom_range(0, 511) - 256);
      default: return COEF_W'($urandom);
    endcase
  endfunction

  // interleaved operand loads with some noise, usually closed by a multiply
  task automatic send_product();
    int first_left;
    int second_left;
    bit heavy;
    first_left = pick_len();
    second_left = pick_len();
    heavy = ($urandom_range(0, 7) == 0);
    while (first_left > 0 || second_left > 0) begin
      if ($urandom_range(0, 19) == 0) begin
        send_word(CMD_UNUSED, COEF_W'($urandom));
      end else if (second_left == 0 || (first_left > 0 && $urandom_range(0, 1))) begin
        send_word(CMD_LOAD_P, pick_coef(heavy));
        first_left--;
      end else begin
        send_word(CMD_LOAD_Q, pick_coef(heavy));
        second_left--;
      end
    end
    if ($urandom_range(0, 9) != 0) send_word(CMD_MULT, COEF_W'($urandom));
  endtask

  // receiver: checks accepted terms and stalls on its own pattern
  initial begin
    int hold_left;
    int window_left;
    int mode;
    logic [15:0] pattern;
    logic next_ready;
    term_word_t seen;
    hold_left = 0;
    window_left = 0;
    mode = 0;
    pattern = '1;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_chan.valid && out_chan.ready) begin
        seen.power = out_chan.power;
        seen.product_term = out_chan.product_term;
        seen.last_term = out_chan.last_term;
        seen.overflow = out_chan.overflow;
        conv.check_word(seen);
      end
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        next_ready = 1'b0;
        hold_left--;
      end else begin
        if (window_left == 0) begin
          mode = $urandom_range(0, 3);
          pattern = 16'($urandom);
          window_left = 64;
        end
        window_left--;
        case (mode)
          0:       next_ready = 1'b1;
          1:       next_ready = 1'($urandom_range(0, 1));
          2:       next_ready = pattern[window_left % 16];
          default: next_ready = ($urandom_range(0, 9) != 0);
        endcase
      end
      out_chan.ready <= next_ready;
    end
  end

  // stimulus
  initial begin
    in_chan.valid       <= 1'b0;
    in_chan.command     <= CMD_LOAD_P;
    in_chan.coefficient <= '0;
    rst_n <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // both operands empty
    send_word(CMD_MULT, 16'sd0);
    // second operand empty
    send_word(CMD_LOAD_P, 16'sd32767);
    send_word(CMD_MULT, -16'sd1);
    // first operand empty, unused code in between
    send_word(CMD_LOAD_Q, -16'sd1);
    send_word(CMD_UNUSED, -16'sd1);
    send_word(CMD_MULT, 16'sd0);
    // middle term saturates high
    repeat (3) send_word(CMD_LOAD_P, -16'sd32768);
    repeat (3) send_word(CMD_LOAD_Q, -16'sd32768);
    send_word(CMD_MULT, 16'sd0);
    // middle term saturates low
    repeat (3) send_word(CMD_LOAD_P, 16'sd32767);
    repeat (3) send_word(CMD_LOAD_Q, -16'sd32768);
    send_word(CMD_MULT, 16'sd0);
    // zero and alternating bit coefficients
    send_word(CMD_LOAD_P, 16'sd0);
    send_word(CMD_LOAD_Q, 16'sh5a5a);
    send_word(CMD_LOAD_Q, -16'sh5a5b);
    send_word(CMD_MULT, 16'sd0);

    // full operands with dropped loads while the receiver holds off,
    // then keep offering loads so the input stalls behind the product
    wait_drained();
    hold_request = 1'b1;
    for (int i = 0; i < MAX_TERMS + 2; i++) send_word(CMD_LOAD_P, pick_coef(1'b0));
    for (int i = 0; i < MAX_TERMS; i++) send_word(CMD_LOAD_Q, pick_coef(1'b0));
    send_word(CMD_MULT, 16'sd0);
    for (int i = 0; i < 10; i++) send_word(CMD_LOAD_Q, pick_coef(1'b0));
    send_word(CMD_MULT, 16'sd0);
    wait_drained();

    // random products
    words_sent = 0;
    for (int seq = 1; words_sent < RANDOM_WORDS; seq++) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      send_product();
      if (seq % 7 == 0) wait_drained();
    end
    send_word(CMD_MULT, 16'sd0);

    // drain and let the block settle
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (conv.error_count == 0 && conv.pending_terms.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
+incdir+hdl
hdl/pm_pkg.sv
hdl/pm_in_if.sv
hdl/pm_out_if.sv
hdl/pm_ram.sv
hdl/pm_seq.sv
hdl/pm_mac.sv
hdl/polynomial_multiply_top.sv
dv/testbench.sv
